>>> hdl/pidcr_pkg.sv
// Package with the sizes, row layout and id helpers of the coverage ranker.
package pidcr_pkg;

	localparam int LAYERS      = 6;
	localparam int TILE_PIXELS = 4096;
	localparam int PIX_W       = $clog2(TILE_PIXELS);
	localparam int ID_W        = 32;
	localparam int CNT_W       = 16;
	localparam int USED_W      = $clog2(LAYERS + 1);
	localparam int TOT_W       = CNT_W + $clog2(LAYERS);
	localparam int QUOT_W      = CNT_W + 1;
	localparam int CHAN_W      = 4;
	localparam int CHAN_LAST   = 2 * LAYERS + 2;
	localparam int DIV_STEPS   = QUOT_W;
	localparam int STEP_W      = $clog2(DIV_STEPS + 1);

	typedef logic [ID_W-1:0]   id_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [USED_W-1:0] used_t;

	typedef struct packed {
		used_t                used;
		cnt_t  [LAYERS-1:0]   cnt;
		id_t   [LAYERS-1:0]   ids;
	} row_t;

	function automatic id_t id_float_bits(input id_t id);
		id_t r;
		r = id;
		if (id[30:23] == 8'h00 || id[30:23] == 8'hFF) begin
			r[23] = ~id[23];
		end
		return r;
	endfunction

endpackage

>>> hdl/pidcr_div.sv
// Bit-serial restoring divider giving floor(count * 65536 / total).
module pidcr_div
	import pidcr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cnt_t              count,
	input  logic [TOT_W-1:0]  total,
	output logic              done,
	output logic [QUOT_W-1:0] quot
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [TOT_W:0]    rem_q;
	logic [TOT_W-1:0]  div_q;
	logic [QUOT_W-1:0] quot_q;
	logic              ge;
	logic [TOT_W:0]    diff;

	assign ge   = rem_q >= {1'b0, div_q};
	assign diff = ge ? (rem_q - {1'b0, div_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIV_STEPS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= (TOT_W + 1)'(count);
			div_q  <= total;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= {diff[TOT_W-1:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> hdl/pixel_id_coverage_ranker_top.sv
// Top level of the per-pixel object id coverage ranker.
//
// The slave stream takes one beat per item: tuser is the kind (0 adds a sample,
// 1 resolves the pixel) and tdata carries the pixel index and the object id.
// A sample beat reads the pixel row, then updates it and writes it back.
// A resolve beat of a non-empty pixel produces fifteen master beats: three
// preview channels, then id and coverage words per rank and zero padding, with
// tlast on the final one. The rows live in one memory with registered reads.
// Each coverage word of a nonzero id waits for the bit-serial divider. A resolve
// of an empty pixel emits nothing.
// After reset the block sweeps the row memory to zero and holds
// s_tready low meanwhile. The block works on one item at a time, and a stalled
// master side stops the emission until the waiting beat is taken.
module pixel_id_coverage_ranker_top
	import pidcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // pixel_index [11:0], object_id [43:12], zero pad
	input  logic [0:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // word
	output logic [3:0]  m_tuser,   // channel
	output logic        m_tlast
);

	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_RANK, ST_ORDER, ST_EMIT, ST_DIV} state_t;

	row_t mem [TILE_PIXELS];

	state_t             state_q;
	logic               clr_q;
	logic [PIX_W-1:0]   clr_addr_q;
	logic [CHAN_W-1:0]  chan_q;
	logic               div_done_q;
	logic               m_tvalid_q;

	row_t               row_s1;
	logic               kind_q;
	logic [PIX_W-1:0]   pix_q;
	id_t                id_q;
	logic [LAYERS-1:0][USED_W-1:0] rank_q;
	id_t  [LAYERS-1:0]  sid_q;
	cnt_t [LAYERS-1:0]  scnt_q;
	used_t              used_q;
	logic [TOT_W-1:0]   total_q;
	logic               start_q;
	logic [31:0]        m_tdata_q;
	logic [CHAN_W-1:0]  m_tuser_q;
	logic               m_tlast_q;

	logic               s_acc;
	logic               mem_we;
	logic [PIX_W-1:0]   mem_wa;
	row_t               mem_wd;
	row_t               upd_row;
	logic [LAYERS-1:0][USED_W-1:0] rank_c;
	logic [TOT_W-1:0]   total_c;
	id_t  [LAYERS-1:0]  sid_c;
	cnt_t [LAYERS-1:0]  scnt_c;

	logic [CHAN_W-1:0]  c3;
	logic [USED_W-1:0]  rsel;
	logic               rvalid;
	id_t                rid;
	cnt_t               rcnt;
	logic               need_div;
	logic [31:0]        word_c;
	logic               out_free;
	logic               out_load;
	logic               div_start;
	logic               div_done;
	logic [QUOT_W-1:0]  div_quot;

	assign s_tready = (state_q == ST_IDLE) && !clr_q;
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Sample update: bump the first matching slot (saturating) or append a new one while a slot is free.
	always_comb begin
		logic found;
		found   = 1'b0;
		upd_row = row_s1;
		for (int i = 0; i < LAYERS; i++) begin
			if (!found && (USED_W'(i) < row_s1.used) && (row_s1.ids[i] == id_q)) begin
				found = 1'b1;
				if (row_s1.cnt[i] != '1) begin
					upd_row.cnt[i] = row_s1.cnt[i] + 1'b1;
				end
			end
		end
		if (!found && (row_s1.used < USED_W'(LAYERS))) begin
			for (int i = 0; i < LAYERS; i++) begin
				if (USED_W'(i) == row_s1.used) begin
					upd_row.ids[i] = id_q;
					upd_row.cnt[i] = CNT_W'(1);
				end
			end
			upd_row.used = row_s1.used + 1'b1;
		end
	end

	// Stable descending rank of every valid slot, and the sum of counts.
	always_comb begin
		total_c = '0;
		for (int i = 0; i < LAYERS; i++) begin
			rank_c[i] = '0;
			if (USED_W'(i) < row_s1.used) begin
				total_c = total_c + TOT_W'(row_s1.cnt[i]);
			end
			for (int j = 0; j < LAYERS; j++) begin
				if ((USED_W'(j) < row_s1.used) &&
				    ((row_s1.cnt[j] > row_s1.cnt[i]) ||
				     ((row_s1.cnt[j] == row_s1.cnt[i]) && (j < i)))) begin
					rank_c[i] = rank_c[i] + 1'b1;
				end
			end
		end
	end

	always_comb begin
		for (int r = 0; r < LAYERS; r++) begin
			sid_c[r]  = '0;
			scnt_c[r] = '0;
			for (int i = 0; i < LAYERS; i++) begin
				if ((USED_W'(i) < used_q) && (rank_q[i] == USED_W'(r))) begin
					sid_c[r]  = sid_c[r] | row_s1.ids[i];
					scnt_c[r] = scnt_c[r] | row_s1.cnt[i];
				end
			end
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = pix_q;
		mem_wd = row_s1;
		if (clr_q) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = '0;
		end else if (state_q == ST_READ && !kind_q) begin
			mem_we = 1'b1;
			mem_wd = upd_row;
		end else if (state_q == ST_ORDER) begin
			mem_we      = 1'b1;
			mem_wd.used = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (s_acc) begin
			row_s1 <= mem[s_tdata[PIX_W-1:0]];
		end
	end

	// Channel word selection.
	always_comb begin
		c3     = chan_q - CHAN_W'(3);
		rsel   = USED_W'(c3[CHAN_W-1:1]) + USED_W'(start_q);
		rvalid = (chan_q >= CHAN_W'(3)) && (rsel < used_q);
		rid    = '0;
		rcnt   = '0;
		for (int r = 0; r < LAYERS; r++) begin
			if (rvalid && rsel == USED_W'(r)) begin
				rid  = sid_q[r];
				rcnt = scnt_q[r];
			end
		end
		need_div = rvalid && (rid != '0) && c3[0];
		word_c   = '0;
		if (chan_q == CHAN_W'(0)) begin
			word_c = (sid_q[0] != '0) ? id_float_bits(sid_q[0]) : '0;
		end else if (chan_q == CHAN_W'(1)) begin
			word_c = sid_q[0] << 8;
		end else if (chan_q == CHAN_W'(2)) begin
			word_c = sid_q[0] << 16;
		end else if (rvalid && rid != '0) begin
			word_c = c3[0] ? 32'(div_quot) : id_float_bits(rid);
		end
	end

	assign div_start = (state_q == ST_EMIT) && out_free && need_div && !div_done_q;
	assign out_load  = (state_q == ST_EMIT) && out_free && !(need_div && !div_done_q);

	pidcr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.count  (rcnt),
		.total  (total_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			chan_q     <= '0;
			div_done_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == PIX_W'(TILE_PIXELS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (!kind_q || row_s1.used == '0) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RANK;
					end
				end
				ST_RANK: begin
					state_q <= ST_ORDER;
				end
				ST_ORDER: begin
					chan_q     <= '0;
					div_done_q <= 1'b0;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end else if (out_load) begin
						div_done_q <= 1'b0;
						chan_q     <= chan_q + 1'b1;
						if (chan_q == CHAN_W'(CHAN_LAST)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						div_done_q <= 1'b1;
						state_q    <= ST_EMIT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_q <= s_tuser[0];
			pix_q  <= s_tdata[PIX_W-1:0];
			id_q   <= s_tdata[12 +: ID_W];
		end
		if (state_q == ST_READ) begin
			rank_q  <= rank_c;
			total_q <= total_c;
			used_q  <= row_s1.used;
		end
		if (state_q == ST_ORDER) begin
			sid_q   <= sid_c;
			scnt_q  <= scnt_c;
			start_q <= (used_q > USED_W'(1)) && (sid_c[0] == '0);
		end
		if (out_load) begin
			m_tdata_q <= word_c;
			m_tuser_q <= chan_q;
			m_tlast_q <= (chan_q == CHAN_W'(CHAN_LAST));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule
